FILE: rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    localparam int unsigned CNT_W    = 16;
    localparam int unsigned WIDTH_W  = 8;
    localparam int unsigned SENS_W   = 2;
    localparam int unsigned ECHO_W   = 3;
    localparam int unsigned DIST_W   = 11;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    // 2^21 / 58 rounded up; exact for every 16-bit dividend.
    localparam int unsigned DIV58_MULT  = 36158;
    localparam int unsigned DIV58_SHIFT = 21;
    localparam int unsigned PROD_W      = 32;

    localparam logic [CNT_W-1:0]   RST_CLEAR_TO = 16'd10000;
    localparam logic [WIDTH_W-1:0] RST_TRIG_W   = 8'd10;
    localparam logic [CNT_W-1:0]   RST_RISE_TO  = 16'd4000;
    localparam logic [CNT_W-1:0]   RST_MAX_ECHO = 16'd4000;

    typedef enum logic [1:0] {
        REG_CLEAR_TO = 2'd0,
        REG_TRIG_W   = 2'd1,
        REG_RISE_TO  = 2'd2,
        REG_MAX_ECHO = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_RISE  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0]   clear_timeout_us;
        logic [WIDTH_W-1:0] trigger_width_us;
        logic [CNT_W-1:0]   rise_timeout_us;
        logic [CNT_W-1:0]   max_echo_us;
    } t_cfg;

endpackage

FILE: rtl/ultrasonic_echo_ranger.sv
// An accepted transaction passes the input register, then the result register; a stall holds it.
// Throughput: one transaction per cycle while i_out_ready does not stall the result register.
// The input register and the result register decouple both sides, so a new
// transaction is taken while a finished result waits, if the input register is empty.
// Reset: synchronous, active low; clears phase, count, sensor, valid flags and
// restores the register defaults. No memory, so no clearing pass.
module ultrasonic_echo_ranger #(
    parameter int unsigned NUM_SENSORS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [uer_pkg::SENS_W-1:0]  i_sensor_select,
    input  logic [uer_pkg::ECHO_W-1:0]  i_echo_levels,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [uer_pkg::ECHO_W-1:0]  o_trigger_lines,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [uer_pkg::DIST_W-1:0]  o_distance_cm,
    output logic [1:0]                  o_status,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uer_pkg::ADDR_W-1:0]  paddr,
    input  logic [uer_pkg::DATA_W-1:0]  pwdata,
    output logic [uer_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    uer_pkg::t_cfg               w_cfg;

    // Input register: holds one accepted transaction until the sequencer takes it.
    logic                        r_in_valid;
    logic                        r_cmd;
    logic [uer_pkg::SENS_W-1:0]  r_sensor_select;
    logic [uer_pkg::ECHO_W-1:0]  r_echo_levels;

    logic                        r_out_valid;
    logic                        w_advance;
    logic                        w_step;

    // Advance when the result register is empty or being drained this cycle.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture the payload on acceptance; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd           <= i_cmd;
            r_sensor_select <= i_sensor_select;
            r_echo_levels   <= i_echo_levels;
        end
    end

    uer_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Phase update plus result register; one transaction per step.
    uer_fsm #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_cmd           (r_cmd),
        .i_sensor_select (r_sensor_select),
        .i_echo_levels   (r_echo_levels),
        .i_cfg           (w_cfg),
        .o_trigger_lines (o_trigger_lines),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_cm   (o_distance_cm),
        .o_status        (o_status)
    );

`ifndef SYNTHESIS
    // A finishing result always leaves the block idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done result reports busy");

    // A distance appears only on a successful finishing result.
    a_dist_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_distance_cm != '0
            |-> o_done_res && o_status == uer_pkg::ST_OK)
        else $error("distance outside a successful finish");

    // At most one trigger line, and only during a measurement.
    a_trig_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_trigger_lines)
            && (o_trigger_lines == '0 || o_busy_res))
        else $error("bad trigger drive");

    // A failure status comes only with a finishing result.
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != uer_pkg::ST_OK |-> o_done_res)
        else $error("status without finish");
`endif

endmodule

FILE: rtl/uer_apb_regs.sv
// APB configuration registers of the echo ranger.
module uer_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uer_pkg::ADDR_W-1:0]  paddr,
    input  logic [uer_pkg::DATA_W-1:0]  pwdata,
    output logic [uer_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output uer_pkg::t_cfg               o_cfg
);

    uer_pkg::t_cfg    r_cfg;
    uer_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = uer_pkg::t_reg_idx'(paddr[uer_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clear_timeout_us <= uer_pkg::RST_CLEAR_TO;
            r_cfg.trigger_width_us <= uer_pkg::RST_TRIG_W;
            r_cfg.rise_timeout_us  <= uer_pkg::RST_RISE_TO;
            r_cfg.max_echo_us      <= uer_pkg::RST_MAX_ECHO;
        end else if (w_wr) begin
            unique case (w_idx)
                uer_pkg::REG_CLEAR_TO:
                    r_cfg.clear_timeout_us <= pwdata[uer_pkg::CNT_W-1:0];
                uer_pkg::REG_TRIG_W:
                    r_cfg.trigger_width_us <= pwdata[uer_pkg::WIDTH_W-1:0];
                uer_pkg::REG_RISE_TO:
                    r_cfg.rise_timeout_us  <= pwdata[uer_pkg::CNT_W-1:0];
                uer_pkg::REG_MAX_ECHO:
                    r_cfg.max_echo_us      <= pwdata[uer_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            uer_pkg::REG_CLEAR_TO: prdata = uer_pkg::DATA_W'(r_cfg.clear_timeout_us);
            uer_pkg::REG_TRIG_W:   prdata = uer_pkg::DATA_W'(r_cfg.trigger_width_us);
            uer_pkg::REG_RISE_TO:  prdata = uer_pkg::DATA_W'(r_cfg.rise_timeout_us);
            uer_pkg::REG_MAX_ECHO: prdata = uer_pkg::DATA_W'(r_cfg.max_echo_us);
            default:               prdata = '0;
        endcase
    end

endmodule

FILE: rtl/uer_div58.sv
// Divide a 16-bit microsecond count by 58 through a reciprocal multiply.
module uer_div58 (
    input  logic [uer_pkg::CNT_W-1:0]  i_value,
    output logic [uer_pkg::DIST_W-1:0] o_quot
);

    logic [uer_pkg::PROD_W-1:0] w_prod;

    assign w_prod = uer_pkg::PROD_W'(i_value)
                  * uer_pkg::PROD_W'(uer_pkg::DIV58_MULT);
    assign o_quot = w_prod[uer_pkg::DIV58_SHIFT +: uer_pkg::DIST_W];

endmodule

FILE: rtl/uer_fsm.sv
// Measurement phase sequencer and result register of the echo ranger.
module uer_fsm #(
    parameter int unsigned NUM_SENSORS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_cmd,
    input  logic [uer_pkg::SENS_W-1:0]  i_sensor_select,
    input  logic [uer_pkg::ECHO_W-1:0]  i_echo_levels,
    input  uer_pkg::t_cfg               i_cfg,
    output logic [uer_pkg::ECHO_W-1:0]  o_trigger_lines,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [uer_pkg::DIST_W-1:0]  o_distance_cm,
    output logic [1:0]                  o_status
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CLEAR = 3'd1,
        PH_TRIG  = 3'd2,
        PH_RISE  = 3'd3,
        PH_ECHO  = 3'd4
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [uer_pkg::CNT_W-1:0]   r_elapsed, n_elapsed;
    logic [uer_pkg::SENS_W-1:0]  r_sensor, n_sensor;

    logic [uer_pkg::ECHO_W-1:0]  r_trig;
    logic                        r_busy;
    logic                        r_done;
    logic [uer_pkg::DIST_W-1:0]  r_dist;
    uer_pkg::t_status            r_status;

    logic                        n_done;
    logic                        n_use_quot;
    uer_pkg::t_status            n_status;
    logic [uer_pkg::ECHO_W-1:0]  n_trig;
    logic [uer_pkg::DIST_W-1:0]  n_dist;

    logic                        w_echo;
    logic                        w_sel_ok;
    logic [uer_pkg::CNT_W-1:0]   w_inc;
    logic [uer_pkg::DIST_W-1:0]  w_quot;

    uer_div58 u_div58 (
        .i_value (r_elapsed),
        .o_quot  (w_quot)
    );

    assign w_inc    = r_elapsed + uer_pkg::CNT_W'(1);
    assign w_sel_ok = {2'b00, i_sensor_select} < 4'(NUM_SENSORS);
    // A sensor beyond the echo field reads as a low line.
    assign w_echo   = ({1'b0, r_sensor} < 3'(uer_pkg::ECHO_W))
                    ? i_echo_levels[r_sensor] : 1'b0;

    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_sensor   = r_sensor;
        n_done     = 1'b0;
        n_use_quot = 1'b0;
        n_status   = uer_pkg::ST_OK;

        if (i_cmd) begin
            // Start is taken only when idle and the sensor exists.
            if (r_phase == PH_IDLE && w_sel_ok) begin
                n_phase   = PH_CLEAR;
                n_elapsed = '0;
                n_sensor  = i_sensor_select;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_CLEAR: begin
                    if (!w_echo || r_elapsed >= i_cfg.clear_timeout_us) begin
                        n_phase   = PH_TRIG;
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = w_inc;
                    end
                end
                PH_TRIG: begin
                    if (w_inc >= uer_pkg::CNT_W'(i_cfg.trigger_width_us)) begin
                        n_phase   = PH_RISE;
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = w_inc;
                    end
                end
                PH_RISE: begin
                    if (w_echo) begin
                        n_phase   = PH_ECHO;
                        n_elapsed = '0;
                    end else if (w_inc >= i_cfg.rise_timeout_us) begin
                        n_phase   = PH_IDLE;
                        n_elapsed = '0;
                        n_done    = 1'b1;
                        n_status  = uer_pkg::ST_NO_RISE;
                    end else begin
                        n_elapsed = w_inc;
                    end
                end
                PH_ECHO: begin
                    if (w_echo) begin
                        if (w_inc >= i_cfg.max_echo_us) begin
                            n_phase   = PH_IDLE;
                            n_elapsed = '0;
                            n_done    = 1'b1;
                            n_status  = uer_pkg::ST_TOO_LONG;
                        end else begin
                            n_elapsed = w_inc;
                        end
                    end else begin
                        n_phase   = PH_IDLE;
                        n_elapsed = '0;
                        n_done    = 1'b1;
                        if (r_elapsed == '0) begin
                            n_status = uer_pkg::ST_ZERO;
                        end else begin
                            n_use_quot = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_trig = '0;
        if (n_phase == PH_TRIG && {1'b0, n_sensor} < 3'(uer_pkg::ECHO_W)) begin
            n_trig[n_sensor] = 1'b1;
        end
        n_dist = n_use_quot ? w_quot : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_sensor  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_sensor  <= n_sensor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_trig   <= n_trig;
            r_busy   <= (n_phase != PH_IDLE);
            r_done   <= n_done;
            r_dist   <= n_dist;
            r_status <= n_status;
        end
    end

    assign o_trigger_lines = r_trig;
    assign o_busy_res      = r_busy;
    assign o_done_res      = r_done;
    assign o_distance_cm   = r_dist;
    assign o_status        = r_status;

endmodule
